// ===== hw/rtl/mva_pkg.sv =====
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types, widths and constants of the mesh volume accumulator.
// ----------------------------------------------------------------------------
package mva_pkg;

  // coordinate and field widths
  localparam int unsigned CoordWidthDefault = 16;
  localparam int unsigned FieldW            = 16;
  localparam int unsigned Axes              = 3;
  localparam int unsigned AxisW             = 2;

  // accumulator and result
  localparam int unsigned SumW    = 63;
  localparam int unsigned SumExtW = SumW + 1;
  localparam int unsigned VolW    = 61;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  // divide by six, one 16-bit quotient digit per step, msb digit first
  localparam int unsigned VolumeDivisor = 6;
  localparam int unsigned RemW          = 3;
  localparam int unsigned DivW          = SumExtW;
  localparam int unsigned DigitW        = 16;
  localparam int unsigned DivValW       = RemW + DigitW;
  localparam int unsigned DivSteps      = DivW / DigitW;
  localparam int unsigned DivCntW       = $clog2(DivSteps);
  // digit of {rem, chunk} / 6 is ({rem, chunk} * ceil(2^21 / 6)) >> 21
  localparam int unsigned RecipShift    = 21;
  localparam int unsigned RecipW        = 19;
  localparam logic [RecipW-1:0] Recip   = 19'd349526;
  localparam int unsigned DivProdW      = DivValW + RecipW;

  // multiplier schedule: six cross-product passes, then six dot-product passes
  localparam int unsigned CrossOps = 2 * Axes;
  localparam int unsigned MulOps   = 4 * Axes;
  localparam int unsigned OpW      = $clog2(MulOps);

  // configuration port
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCenterX     = 4'd0,
    CfgCenterY     = 4'd1,
    CfgCenterZ     = 4'd2,
    CfgSolidEnable = 4'd3
  } mva_cfg_idx_e;

  typedef struct packed {
    logic signed [FieldW-1:0] vertex_x;
    logic signed [FieldW-1:0] vertex_y;
    logic signed [FieldW-1:0] vertex_z;
    logic                     face_start;
    logic                     mesh_end;
  } mva_vertex_t;

  typedef struct packed {
    logic [VolW-1:0] volume;
    logic            saturated;
  } mva_result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } mva_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic           load;
    logic           check;
    logic           mul_en;
    logic [OpW-1:0] op;
    logic           sum;
    logic           update;
    logic           div_step;
    logic           out_load;
  } mva_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic triangle;
    logic mesh_end;
    logic out_free;
  } mva_status_t;

endpackage

// ===== hw/rtl/mva_stream_if.sv =====
// ----------------------------------------------------------------------------
// mva_stream_if
// Valid/ready channel with a typed payload, used for every block channel.
// ----------------------------------------------------------------------------
interface mva_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

// ===== hw/rtl/mva_ctrl.sv =====
// ----------------------------------------------------------------------------
// mva_ctrl
// Sequencer: steps one vertex through diff, multiply, sum, update and divide.
// ----------------------------------------------------------------------------
module mva_ctrl
  import mva_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  mva_status_t status_i,
  output mva_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CHECK  = 8'b0000_0010,
    ST_MUL    = 8'b0000_0100,
    ST_DRAIN  = 8'b0000_1000,
    ST_SUM    = 8'b0001_0000,
    ST_UPDATE = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } mva_state_e;

  mva_state_e         state_q, state_d;
  logic [OpW-1:0]     step_q, step_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    dcnt_d     = dcnt_q;
    cmd_o      = '0;
    cmd_o.op   = step_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        step_d      = '0;
        state_d     = status_i.triangle ? ST_MUL : ST_UPDATE;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (step_q == OpW'(MulOps - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      // last product lands in the accumulator
      ST_DRAIN: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        dcnt_d       = '0;
        state_d      = status_i.mesh_end ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (dcnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = ST_EMIT;
        end else begin
          dcnt_d = dcnt_q + 1'b1;
        end
      end
      // wait for the result register to be free
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      dcnt_q  <= dcnt_d;
    end
  end

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (step_q < OpW'(MulOps)))
    else $error("multiply step out of schedule");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (dcnt_q <= DivCntW'(DivSteps - 1)))
    else $error("divide step count overrun");

  a_sum_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> ($past(state_q) == ST_DRAIN))
    else $error("sum taken before the last product drained");

endmodule

// ===== hw/rtl/mva_dp.sv =====
// ----------------------------------------------------------------------------
// mva_dp
// Datapath: face registers, shared multiplier, saturating accumulator,
// digit-wise divide by six and result register.
// ----------------------------------------------------------------------------
module mva_dp
  import mva_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mva_vertex_t vtx_i,
  input  logic        cfg_we_i,
  input  mva_cfg_t    cfg_i,
  input  mva_cmd_t    cmd_i,
  input  logic        res_ready_i,
  output mva_status_t status_o,
  output logic        res_valid_o,
  output mva_result_t res_o
);

  localparam int unsigned DiffW  = COORD_WIDTH + 1;
  localparam int unsigned OpndW  = DiffW + 1;
  localparam int unsigned ProdW  = 2 * OpndW;
  localparam int unsigned CrossW = 2 * DiffW;
  localparam int unsigned TripW  = 3 * DiffW + 2;

  // configuration
  logic [CfgDataW-1:0] ctr_q [Axes];
  logic                solid_q;

  // current item and face state
  logic signed [COORD_WIDTH-1:0] cur_q  [Axes];
  logic signed [COORD_WIDTH-1:0] org_q  [Axes];
  logic signed [COORD_WIDTH-1:0] prev_q [Axes];
  logic signed [COORD_WIDTH-1:0] vin    [Axes];
  logic                          start_q, end_q;
  logic [1:0]                    count_q;

  // differences against the face origin
  logic signed [DiffW-1:0] da_q [Axes];
  logic signed [DiffW-1:0] db_q [Axes];
  logic signed [DiffW-1:0] dd_q [Axes];

  // multiplier and accumulators
  logic [OpW-1:0]           op_loc;
  logic                     op_dot, op_part;
  logic [AxisW-1:0]         op_axis;
  logic signed [DiffW-1:0]  bj, bl, dj, dl, ak;
  logic signed [CrossW-1:0] ck;
  logic signed [OpndW-1:0]  opa, opb;
  logic signed [ProdW-1:0]  prod_q;
  logic                     prod_vld_q, prod_dot_q, prod_part_q;
  logic [AxisW-1:0]         prod_axis_q;
  logic signed [CrossW-1:0] crs_q [Axes];
  logic signed [TripW-1:0]  prod_ext, prod_sh, t_q;

  // sum and divider
  logic [TripW-1:0]    t_abs;
  logic [SumExtW-1:0]  sum_ext;
  logic [SumW-1:0]     sum_q;
  logic [DivW-1:0]     div_q;
  logic                ovf_q, dsat_q;
  logic [RemW-1:0]     rem_q;
  logic [DivValW-1:0]  dval, dsub, drem;
  logic [DivProdW-1:0] dprod;
  logic [DigitW-1:0]   qdig;

  logic        out_valid_q;
  mva_result_t out_q;

  assign vin[0] = vtx_i.vertex_x[COORD_WIDTH-1:0];
  assign vin[1] = vtx_i.vertex_y[COORD_WIDTH-1:0];
  assign vin[2] = vtx_i.vertex_z[COORD_WIDTH-1:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Axes; k++) begin
        ctr_q[k] <= '0;
      end
      solid_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_i.index)
        CfgCenterX:     ctr_q[0] <= cfg_i.data;
        CfgCenterY:     ctr_q[1] <= cfg_i.data;
        CfgCenterZ:     ctr_q[2] <= cfg_i.data;
        CfgSolidEnable: solid_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // captured request and differences
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < Axes; k++) begin
        cur_q[k] <= vin[k];
      end
      start_q <= vtx_i.face_start;
      end_q   <= vtx_i.mesh_end;
    end
    if (cmd_i.check) begin
      for (int k = 0; k < Axes; k++) begin
        da_q[k] <= {ctr_q[k][COORD_WIDTH-1], ctr_q[k][COORD_WIDTH-1:0]}
                 - {org_q[k][COORD_WIDTH-1], org_q[k]};
        db_q[k] <= {prev_q[k][COORD_WIDTH-1], prev_q[k]}
                 - {org_q[k][COORD_WIDTH-1], org_q[k]};
        dd_q[k] <= {cur_q[k][COORD_WIDTH-1], cur_q[k]}
                 - {org_q[k][COORD_WIDTH-1], org_q[k]};
      end
    end
  end

  // operand select: cross_k = b_j*d_l - b_l*d_j, then a_k times low and high halves
  always_comb begin
    op_dot  = (cmd_i.op >= OpW'(CrossOps));
    op_loc  = op_dot ? (cmd_i.op - OpW'(CrossOps)) : cmd_i.op;
    op_axis = op_loc[AxisW:1];
    op_part = op_loc[0];
    case (op_axis)
      2'd0: begin
        bj = db_q[1]; bl = db_q[2]; dj = dd_q[1]; dl = dd_q[2];
        ak = da_q[0]; ck = crs_q[0];
      end
      2'd1: begin
        bj = db_q[2]; bl = db_q[0]; dj = dd_q[2]; dl = dd_q[0];
        ak = da_q[1]; ck = crs_q[1];
      end
      2'd2: begin
        bj = db_q[0]; bl = db_q[1]; dj = dd_q[0]; dl = dd_q[1];
        ak = da_q[2]; ck = crs_q[2];
      end
      default: begin
        bj = '0; bl = '0; dj = '0; dl = '0;
        ak = '0; ck = '0;
      end
    endcase
    if (op_dot) begin
      opa = {ak[DiffW-1], ak};
      opb = op_part ? {ck[CrossW-1], ck[CrossW-1:DiffW]} : {1'b0, ck[DiffW-1:0]};
    end else begin
      opa = op_part ? {bl[DiffW-1], bl} : {bj[DiffW-1], bj};
      opb = op_part ? {dj[DiffW-1], dj} : {dl[DiffW-1], dl};
    end
  end

  assign prod_ext = {{(TripW - ProdW){prod_q[ProdW-1]}}, prod_q};
  assign prod_sh  = {prod_ext[TripW-DiffW-1:0], {DiffW{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= opa * opb;
    prod_dot_q  <= op_dot;
    prod_part_q <= op_part;
    prod_axis_q <= op_axis;
    if (cmd_i.check) begin
      t_q <= '0;
    end else if (prod_vld_q && prod_dot_q) begin
      t_q <= t_q + (prod_part_q ? prod_sh : prod_ext);
    end
    for (int k = 0; k < Axes; k++) begin
      if (prod_vld_q && !prod_dot_q && (prod_axis_q == AxisW'(k))) begin
        crs_q[k] <= prod_part_q ? (crs_q[k] - prod_q[CrossW-1:0]) : prod_q[CrossW-1:0];
      end
    end
  end

  assign t_abs   = t_q[TripW-1] ? (~t_q + 1'b1) : t_q;
  assign sum_ext = {1'b0, sum_q} + {{(SumExtW - TripW){1'b0}}, t_abs};

  // face state and saturating accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Axes; k++) begin
        org_q[k]  <= '0;
        prev_q[k] <= '0;
      end
      count_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.sum) begin
        if (sum_ext[SumW]) begin
          sum_q <= SumMax;
          ovf_q <= 1'b1;
        end else begin
          sum_q <= sum_ext[SumW-1:0];
        end
      end
      if (cmd_i.update) begin
        if (start_q || (count_q == 2'd0)) begin
          for (int k = 0; k < Axes; k++) begin
            org_q[k]  <= cur_q[k];
            prev_q[k] <= cur_q[k];
          end
          count_q <= 2'd1;
        end else begin
          for (int k = 0; k < Axes; k++) begin
            prev_q[k] <= cur_q[k];
          end
          count_q <= 2'd2;
        end
        // mesh closes: state starts over
        if (end_q) begin
          for (int k = 0; k < Axes; k++) begin
            org_q[k]  <= '0;
            prev_q[k] <= '0;
          end
          count_q <= '0;
          sum_q   <= '0;
          ovf_q   <= 1'b0;
        end
      end
    end
  end

  // long division by six in 16-bit digits, msb digit first
  assign dval  = {rem_q, div_q[DivW-1 -: DigitW]};
  assign dprod = DivProdW'(dval) * DivProdW'(Recip);
  assign qdig  = dprod[RecipShift +: DigitW];
  assign dsub  = DivValW'(qdig) * DivValW'(VolumeDivisor);
  assign drem  = dval - dsub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (cmd_i.update) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= drem[RemW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      div_q  <= solid_q ? {1'b0, sum_q} : '0;
      dsat_q <= solid_q & ovf_q;
    end else if (cmd_i.div_step) begin
      div_q <= {div_q[DivW-DigitW-1:0], qdig};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.volume    <= div_q[VolW-1:0];
      out_q.saturated <= dsat_q;
    end
  end

  assign res_valid_o       = out_valid_q;
  assign res_o             = out_q;
  assign status_o.triangle = !start_q && (count_q == 2'd2);
  assign status_o.mesh_end = end_q;
  assign status_o.out_free = !out_valid_q || res_ready_i;

  a_sat_pins_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (sum_q == SumMax))
    else $error("saturation flag set with accumulator below max");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("face vertex count past two");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < RemW'(VolumeDivisor))
    else $error("divider remainder not below divisor");

endmodule

// ===== hw/rtl/mesh_volume_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// mesh_volume_accumulator_top
// Streams mesh vertices, sums |triple product| per fan triangle, reports
// the enclosed volume (sum / 6, zero with solid off) on the mesh-end vertex.
//
//   channel    dir   payload         handshake
//   vertex_i   in    mva_vertex_t    valid/ready, request per vertex
//   result_o   out   mva_result_t    valid/ready, one request per mesh
//   cfg_i      in    mva_cfg_t       valid/ready, always ready
//
// a vertex that only opens or extends a face passes through check and update;
// a vertex that closes a fan triangle also makes 12 passes through the one shared
// multiplier, then drain and sum. a mesh-end vertex then runs the divide by six,
// 16 quotient bits per cycle, and loads the result register. one vertex is in
// flight at a time. reset clears face state and config (solid on, center
// zero). a result waiting on result_o does not stall input; a later mesh end
// waits for it.
// ----------------------------------------------------------------------------
module mesh_volume_accumulator_top
  import mva_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDefault
) (
  input logic          clk_i,
  input logic          rst_ni,
  mva_stream_if.sink   vertex_i,
  mva_stream_if.source result_o,
  mva_stream_if.sink   cfg_i
);

  mva_cmd_t    cmd;
  mva_status_t status;
  logic        in_ready;
  logic        res_valid;
  mva_result_t res;

  assign vertex_i.ready  = in_ready;
  assign cfg_i.ready     = 1'b1;
  assign result_o.valid  = res_valid;
  assign result_o.payload = res;

  mva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vertex_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mva_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vtx_i       (vertex_i.payload),
    .cfg_we_i    (cfg_i.valid),
    .cfg_i       (cfg_i.payload),
    .cmd_i       (cmd),
    .res_ready_i (result_o.ready),
    .status_o    (status),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

endmodule

// ===== bench/mva_volume_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mva_volume_checker
// Watches the vertex, result and config channels of the mesh volume
// accumulator. Keeps its own copy of the face state and the config, predicts
// the volume reported on each mesh end, and compares every result.
// ----------------------------------------------------------------------------
module mva_volume_checker
  import mva_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vertex_valid_i,
  input  logic        vertex_ready_i,
  input  mva_vertex_t vertex_i,
  input  logic        result_valid_i,
  input  logic        result_ready_i,
  input  mva_result_t result_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  mva_cfg_t    cfg_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef struct {
    longint x;
    longint y;
    longint z;
  } point_t;

  point_t          center;
  logic            solid;
  point_t          face_origin;
  point_t          face_prev;
  int unsigned     face_len;
  logic [SumW-1:0] volume_sum;
  logic            sum_clipped;
  mva_result_t     expected_volumes_q[$];
  mva_result_t     oldest;
  int              fail_count;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
    fail_count   = 0;
  end

  function automatic longint coord(logic [FieldW-1:0] raw);
    return longint'($signed(raw));
  endfunction

  // |(c - o) . ((p - o) x (v - o))|, six times the tetrahedron volume
  function automatic logic [SumW-1:0] tetra_term(point_t c, point_t o, point_t p, point_t v);
    longint ax, ay, az, bx, by, bz, dx, dy, dz, cx, cy, cz, t;
    ax = c.x - o.x;
    ay = c.y - o.y;
    az = c.z - o.z;
    bx = p.x - o.x;
    by = p.y - o.y;
    bz = p.z - o.z;
    dx = v.x - o.x;
    dy = v.y - o.y;
    dz = v.z - o.z;
    cx = by * dz - bz * dy;
    cy = bz * dx - bx * dz;
    cz = bx * dy - by * dx;
    t  = ax * cx + ay * cy + az * cz;
    if (t < 0) begin
      t = -t;
    end
    return t[SumW-1:0];
  endfunction

  task automatic clear_mesh();
    face_origin = '{0, 0, 0};
    face_prev   = '{0, 0, 0};
    face_len    = 0;
    volume_sum  = '0;
    sum_clipped = 1'b0;
  endtask

  task automatic accumulate_vertex(mva_vertex_t vtx);
    point_t          cur;
    logic [SumW-1:0] term;
    mva_result_t     res;
    cur.x = coord(vtx.vertex_x);
    cur.y = coord(vtx.vertex_y);
    cur.z = coord(vtx.vertex_z);
    // with no face open, any vertex opens one
    if (vtx.face_start || face_len == 0) begin
      face_origin = cur;
      face_prev   = cur;
      face_len    = 1;
    end else if (face_len == 1) begin
      face_prev = cur;
      face_len  = 2;
    end else begin
      term = tetra_term(center, face_origin, face_prev, cur);
      if (term > SumMax - volume_sum) begin
        volume_sum  = SumMax;
        sum_clipped = 1'b1;
      end else begin
        volume_sum = volume_sum + term;
      end
      face_prev = cur;
    end
    if (vtx.mesh_end) begin
      if (solid) begin
        res.volume    = VolW'(volume_sum / VolumeDivisor);
        res.saturated = sum_clipped;
      end else begin
        res = '0;
      end
      expected_volumes_q.push_back(res);
      clear_mesh();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center = '{0, 0, 0};
      solid  = 1'b1;
      clear_mesh();
      expected_volumes_q.delete();
    end else begin
      if (result_valid_i && result_ready_i) begin
        if (expected_volumes_q.size() == 0) begin
          $error("result with no mesh end pending: volume %0d, saturated %0b",
                 result_i.volume, result_i.saturated);
          fail_count++;
        end else begin
          oldest = expected_volumes_q.pop_front();
          if (result_i.volume !== oldest.volume) begin
            $error("volume: expected %0d, got %0d", oldest.volume, result_i.volume);
            fail_count++;
          end
          if (result_i.saturated !== oldest.saturated) begin
            $error("saturated: expected %0b, got %0b", oldest.saturated, result_i.saturated);
            fail_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_i.index)
          CfgCenterX:     center.x = coord(cfg_i.data);
          CfgCenterY:     center.y = coord(cfg_i.data);
          CfgCenterZ:     center.z = coord(cfg_i.data);
          CfgSolidEnable: solid    = cfg_i.data[0];
          default: ;
        endcase
      end
      if (vertex_valid_i && vertex_ready_i) begin
        accumulate_vertex(vertex_i);
      end
    end
    pending_o    <= expected_volumes_q.size();
    fail_count_o <= fail_count;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives mesh vertices and config writes into the mesh volume accumulator
// with random gaps and result stalls; a separate checker predicts and
// compares the volumes, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import mva_pkg::*;

  localparam int unsigned PhaseItems      = 88;
  localparam int unsigned LongHoldCycles  = 600;
  localparam int unsigned SettleCycles    = 96;

  logic        clk;
  logic        rst_n;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          hold_requests;
  int unsigned items_sent;
  int          pending_results;
  int          fail_count;

  mva_stream_if #(.payload_t(mva_vertex_t)) vertex_if ();
  mva_stream_if #(.payload_t(mva_result_t)) result_if ();
  mva_stream_if #(.payload_t(mva_cfg_t))    cfg_if ();

  mesh_volume_accumulator_top dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .vertex_i (vertex_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  mva_volume_checker volume_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .vertex_valid_i (vertex_if.valid),
    .vertex_ready_i (vertex_if.ready),
    .vertex_i       (vertex_if.payload),
    .result_valid_i (result_if.valid),
    .result_ready_i (result_if.ready),
    .result_i       (result_if.payload),
    .cfg_valid_i    (cfg_if.valid),
    .cfg_ready_i    (cfg_if.ready),
    .cfg_i          (cfg_if.payload),
    .pending_o      (pending_results),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** mesh_volume_accumulator_top: FAILED **");
    $finish;
  end

  // result side: random stalls plus long hold-offs on request
  initial begin
    int unsigned hold_left;
    int          hold_served;
    hold_left   = 0;
    hold_served = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = LongHoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic mva_vertex_t vtx(logic [FieldW-1:0] x, y, z, logic fs, me);
    return '{vertex_x: x, vertex_y: y, vertex_z: z, face_start: fs, mesh_end: me};
  endfunction

  function automatic logic [FieldW-1:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return FieldW'($urandom);
      5, 6, 7:       return FieldW'($urandom_range(1023)) - 16'd512;
      default: begin
        case ($urandom_range(3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  task automatic send_vertex(mva_vertex_t v);
    while ($urandom_range(99) < tx_idle_pct) begin
      vertex_if.valid <= 1'b0;
      @(posedge clk);
    end
    vertex_if.valid   <= 1'b1;
    vertex_if.payload <= v;
    @(posedge clk);
    while (!vertex_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // stop sending, wait for every volume, then let any open vertex finish
  task automatic wait_drained();
    vertex_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic program_config(logic [CfgDataW-1:0] cx, cy, cz, logic solid_en);
    mva_cfg_t writes [5];
    writes[0] = '{index: CfgCenterX, data: cx};
    writes[1] = '{index: CfgCenterY, data: cy};
    writes[2] = '{index: CfgCenterZ, data: cz};
    writes[3] = '{index: CfgSolidEnable, data: {15'($urandom), solid_en}};
    // unmapped index, must leave everything alone
    writes[4].index = CfgIdxW'($urandom_range(CfgSolidEnable + 1, 2 ** CfgIdxW - 1));
    writes[4].data  = CfgDataW'($urandom);
    foreach (writes[k]) begin
      cfg_if.valid   <= 1'b1;
      cfg_if.payload <= writes[k];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_random_mesh();
    int unsigned faces;
    int unsigned verts;
    logic        broken;
    faces  = $urandom_range(1, 3);
    // mesh end left off, so this mesh runs into the next one
    broken = ($urandom_range(9) == 0);
    for (int f = 0; f < faces; f++) begin
      verts = ($urandom_range(4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
      for (int k = 0; k < verts; k++) begin
        send_vertex(vtx(rand_coord(), rand_coord(), rand_coord(),
                        (k == 0) && (f != 0 || $urandom_range(1) != 0),
                        !broken && f == faces - 1 && k == verts - 1));
      end
    end
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        send_vertex(vtx(rand_coord(), rand_coord(), rand_coord(),
                        1'($urandom_range(1)), $urandom_range(3) == 0));
      end else begin
        send_random_mesh();
      end
    end
  endtask

  initial begin
    vertex_if.valid   <= 1'b0;
    vertex_if.payload <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.payload    <= '0;
    rst_n             <= 1'b0;
    tx_idle_pct   = 11;
    rx_stall_pct  = 55;
    hold_requests = 0;
    items_sent    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: center at zero, solid on
    // vertex with no face open starts a face on its own
    send_vertex(vtx(16'h0100, 16'h0100, 16'h0100, 1'b0, 1'b0));
    send_vertex(vtx(16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b0));
    send_vertex(vtx(16'h0000, 16'h8000, 16'h0000, 1'b0, 1'b0));
    send_vertex(vtx(16'h0000, 16'h0000, 16'h7fff, 1'b0, 1'b1));
    // one-vertex mesh, mesh end on a face start
    send_vertex(vtx(16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b1));
    // short faces of one and two vertices, then a quad at the corners
    send_vertex(vtx(16'h1234, 16'hedcb, 16'h0001, 1'b1, 1'b0));
    send_vertex(vtx(16'hffff, 16'h0000, 16'h8000, 1'b1, 1'b0));
    send_vertex(vtx(16'h7fff, 16'h8000, 16'hffff, 1'b0, 1'b0));
    send_vertex(vtx(16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b0));
    send_vertex(vtx(16'h8000, 16'h7fff, 16'h8000, 1'b0, 1'b0));
    send_vertex(vtx(16'h8000, 16'h8000, 16'h7fff, 1'b0, 1'b0));
    send_vertex(vtx(16'h7fff, 16'h8000, 16'h8000, 1'b0, 1'b0));
    // face start with mesh end: the new face is dropped with the mesh
    send_vertex(vtx(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1));
    send_vertex(vtx(16'h0200, 16'hfe00, 16'h0080, 1'b1, 1'b0));
    send_vertex(vtx(16'h0400, 16'h0100, 16'hff00, 1'b0, 1'b0));
    send_vertex(vtx(16'h0300, 16'h0500, 16'h0200, 1'b0, 1'b0));
    send_vertex(vtx(16'hfd00, 16'h0400, 16'h0600, 1'b0, 1'b0));
    send_vertex(vtx(16'hfc00, 16'hfb00, 16'h0100, 1'b0, 1'b0));
    // two-vertex face right at the mesh end
    send_vertex(vtx(16'h0200, 16'h0300, 16'h0400, 1'b1, 1'b0));
    send_vertex(vtx(16'hfe00, 16'h0300, 16'h0400, 1'b0, 1'b1));

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct  = (ph == 0) ? 11 : (ph == 1) ? 55 : 0;
      rx_stall_pct = (ph == 0) ? 55 : (ph == 1) ? 11 : 0;
      for (int half = 0; half < 2; half++) begin
        wait_drained();
        case (2 * ph + half)
          0: program_config(16'h8000, 16'h8000, 16'h8000, 1'b1);
          1: program_config(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
          2: program_config(CfgDataW'($urandom), CfgDataW'($urandom),
                            CfgDataW'($urandom), 1'b0);
          default: program_config(CfgDataW'($urandom), CfgDataW'($urandom),
                                  CfgDataW'($urandom), 1'b1);
        endcase
        // results back up while vertices keep coming
        if (ph == 0 && half == 0) begin
          hold_requests++;
        end
        run_random(PhaseItems);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("** mesh_volume_accumulator_top: PASSED **");
    end else begin
      $display("** mesh_volume_accumulator_top: FAILED **");
    end
    $finish;
  end

endmodule
